// ===== rtl/cfmac_pkg.sv =====
// Shared constants, types and binary32 normalize/round functions for the complex FP MAC.
`timescale 1ns / 1ps
`default_nettype none
package cfmac_pkg;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG = 31'h7F80_0000;
  localparam int MUL_STAGES = 3;
  localparam int ADD_STAGES = 4;
  localparam int LATENCY    = MUL_STAGES + 2 * ADD_STAGES;

  // Normalized mantissa: 26 kept bits plus a sticky bit, and the weight of the leading one
  typedef struct packed {
    logic               zero;
    logic [26:0]        v;
    logic signed [10:0] ex;
  } norm_t;

  // Left-justify a magnitude and fold the low bits into a sticky bit
  function automatic norm_t fp_norm(logic [56:0] m, logic signed [10:0] e);
    norm_t       r;
    logic [5:0]  p;
    logic [56:0] sh;
    p = '0;
    for (int i = 0; i < 57; i++) begin
      if (m[i]) p = i[5:0];
    end
    sh     = m << (6'd56 - p);
    r.zero = (m == '0);
    r.v    = {sh[56:31], |sh[30:0]};
    r.ex   = e + $signed({5'b0, p});
    return r;
  endfunction

  // Round to nearest even, with subnormal denormalization and overflow to infinity
  function automatic logic [31:0] fp_round(logic sgn, norm_t n);
    logic signed [10:0] dd;
    logic [4:0]         ext;
    logic [9:0]         bexp;
    logic [26:0]        vs;
    logic [26:0]        lost_mask;
    logic               st;
    logic               up;
    logic [24:0]        q;
    logic [33:0]        sum;
    logic [31:0]        res;
    dd = -11'sd126 - n.ex;
    if (n.ex < -11'sd126) begin
      ext  = (dd > 11'sd27) ? 5'd27 : dd[4:0];
      bexp = '0;
    end else begin
      ext  = '0;
      bexp = 10'(n.ex + 11'sd126);
    end
    lost_mask = ~({27{1'b1}} << ext);
    vs  = n.v >> ext;
    st  = (|(n.v & lost_mask)) | (|vs[1:0]);
    up  = vs[2] & (st | vs[3]);
    q   = {1'b0, vs[26:3]} + {24'b0, up};
    sum = {1'b0, bexp, 23'b0} + {9'b0, q};
    if (n.zero) begin
      res = {sgn, 31'b0};
    end else if (sum[33:23] >= 11'd255) begin
      res = {sgn, INF_MAG};
    end else begin
      res = {sgn, sum[30:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cfmac_in_if.sv =====
// Input channel: factor and accumulator words with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface cfmac_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_real;
  logic [31:0] first_imag;
  logic [31:0] second_real;
  logic [31:0] second_imag;
  logic [31:0] sum_in_real;
  logic [31:0] sum_in_imag;
  logic        last_in;

  modport source (output valid, first_real, first_imag, second_real, second_imag,
                  sum_in_real, sum_in_imag, last_in, input ready);
  modport sink (input valid, first_real, first_imag, second_real, second_imag,
                sum_in_real, sum_in_imag, last_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/cfmac_out_if.sv =====
// Result channel: updated accumulator words with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface cfmac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_out_real;
  logic [31:0] sum_out_imag;
  logic        last_out;

  modport source (output valid, sum_out_real, sum_out_imag, last_out, input ready);
  modport sink (input valid, sum_out_real, sum_out_imag, last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/cfmac_mul.sv =====
// Three-stage binary32 multiplier: mantissa product, normalize, round.
`timescale 1ns / 1ps
`default_nettype none
module cfmac_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      y
);

  // stage 1: specials, unpack, 24x24 product
  logic              nan_a, nan_b, inf_a, inf_b, zro_a, zro_b, sgn;
  logic              spec_nxt;
  logic [31:0]       sval_nxt;
  logic [23:0]       ma, mb;
  logic signed [8:0] ea, eb;

  always_comb begin
    nan_a = a[30:0] > cfmac_pkg::INF_MAG;
    nan_b = b[30:0] > cfmac_pkg::INF_MAG;
    inf_a = a[30:0] == cfmac_pkg::INF_MAG;
    inf_b = b[30:0] == cfmac_pkg::INF_MAG;
    zro_a = a[30:0] == '0;
    zro_b = b[30:0] == '0;
    sgn   = a[31] ^ b[31];
    spec_nxt = 1'b1;
    if (nan_a || nan_b) begin
      sval_nxt = cfmac_pkg::QNAN;
    end else if (inf_a || inf_b) begin
      sval_nxt = (zro_a || zro_b) ? cfmac_pkg::QNAN : {sgn, cfmac_pkg::INF_MAG};
    end else if (zro_a || zro_b) begin
      sval_nxt = {sgn, 31'b0};
    end else begin
      spec_nxt = 1'b0;
      sval_nxt = '0;
    end
    if (a[30:23] == '0) begin
      ma = {1'b0, a[22:0]};
      ea = -9'sd149;
    end else begin
      ma = {1'b1, a[22:0]};
      ea = $signed({1'b0, a[30:23]}) - 9'sd150;
    end
    if (b[30:23] == '0) begin
      mb = {1'b0, b[22:0]};
      eb = -9'sd149;
    end else begin
      mb = {1'b1, b[22:0]};
      eb = $signed({1'b0, b[30:23]}) - 9'sd150;
    end
  end

  logic [47:0]        prod_r;
  logic signed [9:0]  e1_r;
  logic               s1_r, spec1_r;
  logic [31:0]        sval1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= ma * mb;
      e1_r    <= 10'(ea) + 10'(eb);
      s1_r    <= sgn;
      spec1_r <= spec_nxt;
      sval1_r <= sval_nxt;
    end
  end

  // stage 2: normalize
  cfmac_pkg::norm_t n2_r;
  logic             s2_r, spec2_r;
  logic [31:0]      sval2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r    <= cfmac_pkg::fp_norm({9'b0, prod_r}, 11'(e1_r));
      s2_r    <= s1_r;
      spec2_r <= spec1_r;
      sval2_r <= sval1_r;
    end
  end

  // stage 3: round
  logic [31:0] y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= spec2_r ? sval2_r : cfmac_pkg::fp_round(s2_r, n2_r);
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/cfmac_add.sv =====
// Four-stage binary32 adder: align, add/subtract, normalize, round.
`timescale 1ns / 1ps
`default_nettype none
module cfmac_add (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      y
);

  // stage 1: specials, unpack, swap, align smaller operand
  logic              nan_a, nan_b, inf_a, inf_b, zro_a, zro_b;
  logic              spec_nxt;
  logic [31:0]       sval_nxt;
  logic [23:0]       ma, mb, mx, mn;
  logic signed [8:0] ea, eb, ex, en_e, dd;
  logic              sx, sn;
  logic [7:0]        d;
  logic [55:0]       t, lost_mask, mbx_nxt;

  always_comb begin
    nan_a = a[30:0] > cfmac_pkg::INF_MAG;
    nan_b = b[30:0] > cfmac_pkg::INF_MAG;
    inf_a = a[30:0] == cfmac_pkg::INF_MAG;
    inf_b = b[30:0] == cfmac_pkg::INF_MAG;
    zro_a = a[30:0] == '0;
    zro_b = b[30:0] == '0;
    spec_nxt = 1'b1;
    if (nan_a || nan_b) begin
      sval_nxt = cfmac_pkg::QNAN;
    end else if (inf_a && inf_b) begin
      sval_nxt = (a[31] != b[31]) ? cfmac_pkg::QNAN : a;
    end else if (inf_a) begin
      sval_nxt = a;
    end else if (inf_b) begin
      sval_nxt = b;
    end else if (zro_a && zro_b) begin
      sval_nxt = {a[31] & b[31], 31'b0};
    end else if (zro_a) begin
      sval_nxt = b;
    end else if (zro_b) begin
      sval_nxt = a;
    end else begin
      spec_nxt = 1'b0;
      sval_nxt = '0;
    end
    if (a[30:23] == '0) begin
      ma = {1'b0, a[22:0]};
      ea = -9'sd149;
    end else begin
      ma = {1'b1, a[22:0]};
      ea = $signed({1'b0, a[30:23]}) - 9'sd150;
    end
    if (b[30:23] == '0) begin
      mb = {1'b0, b[22:0]};
      eb = -9'sd149;
    end else begin
      mb = {1'b1, b[22:0]};
      eb = $signed({1'b0, b[30:23]}) - 9'sd150;
    end
    if (ea < eb) begin
      mx = mb; ex = eb; sx = b[31];
      mn = ma; en_e = ea; sn = a[31];
    end else begin
      mx = ma; ex = ea; sx = a[31];
      mn = mb; en_e = eb; sn = b[31];
    end
    dd = ex - en_e;
    d  = dd[7:0];
    t  = {mn, 32'b0};
    if (d >= 8'd56) begin
      lost_mask = '1;
      mbx_nxt   = 56'd1;
    end else begin
      lost_mask = ~({56{1'b1}} << d);
      mbx_nxt   = (t >> d) | {55'b0, |(t & lost_mask)};
    end
  end

  logic [23:0]       ma1_r;
  logic [55:0]       mb1_r;
  logic signed [8:0] e1_r;
  logic              sa1_r, sb1_r, spec1_r;
  logic [31:0]       sval1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma1_r   <= mx;
      mb1_r   <= mbx_nxt;
      e1_r    <= ex;
      sa1_r   <= sx;
      sb1_r   <= sn;
      spec1_r <= spec_nxt;
      sval1_r <= sval_nxt;
    end
  end

  // stage 2: magnitude add or subtract
  logic [55:0] maw;
  logic [56:0] m_nxt;
  logic        s_nxt;

  always_comb begin
    maw = {ma1_r, 32'b0};
    if (sa1_r == sb1_r) begin
      m_nxt = {1'b0, maw} + {1'b0, mb1_r};
      s_nxt = sa1_r;
    end else if (maw == mb1_r) begin
      // exact cancellation gives +0
      m_nxt = '0;
      s_nxt = 1'b0;
    end else if (maw > mb1_r) begin
      m_nxt = {1'b0, maw - mb1_r};
      s_nxt = sa1_r;
    end else begin
      m_nxt = {1'b0, mb1_r - maw};
      s_nxt = sb1_r;
    end
  end

  logic [56:0]        m2_r;
  logic signed [10:0] e2_r;
  logic               s2_r, spec2_r;
  logic [31:0]        sval2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r    <= m_nxt;
      e2_r    <= 11'(e1_r) - 11'sd32;
      s2_r    <= s_nxt;
      spec2_r <= spec1_r;
      sval2_r <= sval1_r;
    end
  end

  // stage 3: normalize
  cfmac_pkg::norm_t n3_r;
  logic             s3_r, spec3_r;
  logic [31:0]      sval3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r    <= cfmac_pkg::fp_norm(m2_r, e2_r);
      s3_r    <= s2_r;
      spec3_r <= spec2_r;
      sval3_r <= sval2_r;
    end
  end

  // stage 4: round
  logic [31:0] y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= spec3_r ? sval3_r : cfmac_pkg::fp_round(s3_r, n3_r);
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

// ===== rtl/complex_float_multiply_accumulate.sv =====
// Top level: complex binary32 multiply-accumulate, acc + a*b, fully pipelined.
// Pipeline: 3 multiply, 4 inner add and 4 outer add stages from accepted word to result.
// Throughput: one word per cycle; the whole pipeline advances unless the output
// register holds a word that is not taken.
// Reset: synchronous active-low rst_n clears the valid bits only; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module complex_float_multiply_accumulate (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cfmac_in_if.sink    in_if,
  cfmac_out_if.source out_if
);

  localparam int Lat    = cfmac_pkg::LATENCY;
  localparam int AccDly = cfmac_pkg::MUL_STAGES + cfmac_pkg::ADD_STAGES;

  logic en;
  logic [Lat-1:0] vld_r;
  logic [Lat-1:0] last_r;

  // advance whenever the output slot is empty or being taken
  assign en          = !vld_r[Lat-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r <= {last_r[Lat-2:0], in_if.last_in};
    end
  end

  // accumulator words wait for the products
  logic [31:0] acc_re_r [AccDly];
  logic [31:0] acc_im_r [AccDly];

  always_ff @(posedge clk) begin
    if (en) begin
      acc_re_r[0] <= in_if.sum_in_real;
      acc_im_r[0] <= in_if.sum_in_imag;
      for (int i = 1; i < AccDly; i++) begin
        acc_re_r[i] <= acc_re_r[i-1];
        acc_im_r[i] <= acc_im_r[i-1];
      end
    end
  end

  // four partial products
  logic [31:0] p_rr, p_ii, p_ir, p_ri;

  cfmac_mul u_mul_rr (.clk, .en, .a(in_if.first_real), .b(in_if.second_real), .y(p_rr));
  cfmac_mul u_mul_ii (.clk, .en, .a(in_if.first_imag), .b(in_if.second_imag), .y(p_ii));
  cfmac_mul u_mul_ir (.clk, .en, .a(in_if.first_imag), .b(in_if.second_real), .y(p_ir));
  cfmac_mul u_mul_ri (.clk, .en, .a(in_if.first_real), .b(in_if.second_imag), .y(p_ri));

  // inner sums: re = rr - ii, im = ir + ri
  logic [31:0] prod_re, prod_im;
  logic [31:0] p_ii_neg;

  assign p_ii_neg = {~p_ii[31], p_ii[30:0]};

  cfmac_add u_add_pre (.clk, .en, .a(p_rr), .b(p_ii_neg), .y(prod_re));
  cfmac_add u_add_pim (.clk, .en, .a(p_ir), .b(p_ri), .y(prod_im));

  // accumulate; the outer adders' round stage is the output register
  cfmac_add u_add_re (.clk, .en, .a(acc_re_r[AccDly-1]), .b(prod_re), .y(out_if.sum_out_real));
  cfmac_add u_add_im (.clk, .en, .a(acc_im_r[AccDly-1]), .b(prod_im), .y(out_if.sum_out_imag));

  assign out_if.valid    = vld_r[Lat-1];
  assign out_if.last_out = last_r[Lat-1];

`ifndef ASSERT_OFF
  // an accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> vld_r[0])
    else $error("accepted word did not enter pipeline");

  // a stalled result is neither dropped nor changed
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.sum_out_real)
      && $stable(out_if.sum_out_imag) && $stable(out_if.last_out))
    else $error("stalled result changed");

  // every NaN leaving on the real output is the canonical quiet NaN
  a_qnan: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.sum_out_real[30:0] > cfmac_pkg::INF_MAG)
      |-> out_if.sum_out_real == cfmac_pkg::QNAN)
    else $error("non-canonical NaN on real output");
`endif

endmodule
`default_nettype wire

// ===== verif/cfmac_result_checker.sv =====
// Checker: watches both channels, predicts each accumulator update and compares results.
`timescale 1ns / 1ps
`default_nettype none
module cfmac_result_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  cfmac_in_if       in_ch,
  cfmac_out_if      out_ch,
  output int        err_count,
  output int        pending,
  output int        checked
);

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } acc_word_t;

  acc_word_t acc_expected_q[$];

  function automatic bit is_nan32(logic [31:0] x);
    return x[30:0] > INF_BITS[30:0];
  endfunction

  function automatic bit is_inf32(logic [31:0] x);
    return x[30:0] == INF_BITS[30:0];
  endfunction

  function automatic bit is_zero32(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // value = m * 2^e for a finite nonzero pattern
  function automatic void split32(input logic [31:0] x, output int e,
                                  output longint unsigned m);
    if (x[30:23] == 8'd0) begin
      m = 64'(x[22:0]);
      e = -149;
    end else begin
      m = 64'({1'b1, x[22:0]});
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // Round (-1)^s * m * 2^e to binary32, nearest even, subnormals kept
  function automatic logic [31:0] round_to_single(bit s, int e, longint unsigned m);
    longint unsigned q, t, rem, half;
    int p, sh, lo, biased;
    logic [31:0] sbit;
    sbit = {s, 31'd0};
    if (m == 0) return sbit;
    while ((m >> 40) != 0) begin
      m = (m >> 1) | (m & 1);
      e++;
    end
    p = 0;
    t = m;
    while (t > 1) begin
      t >>= 1;
      p++;
    end
    sh = p - 23;
    lo = -149 - e;
    if (lo > sh) sh = lo;
    if (sh > 41) begin
      q = 0;
    end else if (sh > 0) begin
      rem  = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      q    = m >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end else begin
      q = m << (-sh);
    end
    if (q == (64'd1 << 24)) begin
      q >>= 1;
      sh++;
    end
    if (q < (64'd1 << 23)) return sbit | q[31:0];
    biased = 23 + sh + e + 127;
    if (biased >= 255) return sbit | INF_BITS;
    return sbit | {1'b0, biased[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
    bit s;
    int ea, eb;
    longint unsigned ma, mb;
    s = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return CANON_NAN;
    if (is_inf32(a) || is_inf32(b)) begin
      if (is_zero32(a) || is_zero32(b)) return CANON_NAN;
      return {s, 31'd0} | INF_BITS;
    end
    if (is_zero32(a) || is_zero32(b)) return {s, 31'd0};
    split32(a, ea, ma);
    split32(b, eb, mb);
    return round_to_single(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] single_add(logic [31:0] a, logic [31:0] b);
    bit sa, sb, ts;
    int ea, eb, d, te, r;
    longint unsigned ma, mb, tm, lost;
    sa = a[31];
    sb = b[31];
    if (is_nan32(a) || is_nan32(b)) return CANON_NAN;
    if (is_inf32(a) && is_inf32(b)) return (sa != sb) ? CANON_NAN : a;
    if (is_inf32(a)) return a;
    if (is_inf32(b)) return b;
    if (is_zero32(a) && is_zero32(b)) return {sa & sb, 31'd0};
    if (is_zero32(a)) return b;
    if (is_zero32(b)) return a;
    split32(a, ea, ma);
    split32(b, eb, mb);
    if (ea < eb) begin
      ts = sa; te = ea; tm = ma;
      sa = sb; ea = eb; ma = mb;
      sb = ts; eb = te; mb = tm;
    end
    d = ea - eb;
    ma <<= 32;
    if (d <= 32) begin
      mb <<= (32 - d);
    end else if (d - 32 >= 63) begin
      mb = 1;
    end else begin
      r    = d - 32;
      lost = mb & ((64'd1 << r) - 1);
      mb   = (mb >> r) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    ea -= 32;
    if (sa == sb) return round_to_single(sa, ea, ma + mb);
    if (ma == mb) return 32'd0;
    if (ma > mb) return round_to_single(sa, ea, ma - mb);
    return round_to_single(sb, ea, mb - ma);
  endfunction

  // acc + a*b, one rounding per operation
  function automatic acc_word_t predict_mac(logic [31:0] ar, logic [31:0] ai,
                                            logic [31:0] br, logic [31:0] bi,
                                            logic [31:0] cr, logic [31:0] ci,
                                            logic lst);
    acc_word_t w;
    logic [31:0] prod_re, prod_im;
    prod_re = single_add(single_mul(ar, br), single_mul(ai, bi) ^ SIGN_MASK);
    prod_im = single_add(single_mul(ai, br), single_mul(ar, bi));
    w.re   = single_add(cr, prod_re);
    w.im   = single_add(ci, prod_im);
    w.last = lst;
    return w;
  endfunction

  // Sample both handshakes at the clock edge
  always @(posedge clk) begin
    acc_word_t exp_w;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      acc_expected_q.push_back(predict_mac(in_ch.first_real, in_ch.first_imag,
                                           in_ch.second_real, in_ch.second_imag,
                                           in_ch.sum_in_real, in_ch.sum_in_imag,
                                           in_ch.last_in));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (acc_expected_q.size() == 0) begin
        $display("%0t: unexpected word re=%h im=%h last=%b", $realtime,
                 out_ch.sum_out_real, out_ch.sum_out_imag, out_ch.last_out);
        err_count++;
      end else begin
        exp_w = acc_expected_q.pop_front();
        checked++;
        if (out_ch.sum_out_real !== exp_w.re) begin
          $display("%0t: sum_out_real expected %h actual %h", $realtime,
                   exp_w.re, out_ch.sum_out_real);
          err_count++;
        end
        if (out_ch.sum_out_imag !== exp_w.im) begin
          $display("%0t: sum_out_imag expected %h actual %h", $realtime,
                   exp_w.im, out_ch.sum_out_imag);
          err_count++;
        end
        if (out_ch.last_out !== exp_w.last) begin
          $display("%0t: last_out expected %b actual %b", $realtime,
                   exp_w.last, out_ch.last_out);
          err_count++;
        end
      end
    end
    pending = acc_expected_q.size();
  end

endmodule
`default_nettype wire

// ===== verif/tb_complex_float_multiply_accumulate.sv =====
// Testbench top: drives directed and random words into the complex MAC and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_complex_float_multiply_accumulate;

  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycles;
  int   err_count, pending, checked;
  bit   hold_req;
  bit   quiet;

  cfmac_in_if  in_ch ();
  cfmac_out_if out_ch ();

  complex_float_multiply_accumulate uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  cfmac_result_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .err_count (err_count),
    .pending   (pending),
    .checked   (checked)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** complex_float_multiply_accumulate: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls per word, quiet stretches, one long hold-off on request
  initial begin
    int hold_left, wait_left;
    bit hold_done;
    hold_left = 0;
    wait_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (out_ch.valid && out_ch.ready)
        wait_left = quiet ? 0 : $urandom_range(0, 11);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Random binary32 pattern, weighted toward values that interact
  function automatic logic [31:0] rand_single();
    logic        s;
    int unsigned k;
    s = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 19);
    case (k)
      0:       return {s, 31'd0};
      1:       return {s, 8'hFF, 23'd0};
      2:       return {s, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      3, 4:    return {s, 8'h00, 23'($urandom)};
      5:       return {s, 8'($urandom_range(0, 1) ? 8'hFE : 8'h01), 23'($urandom)};
      6, 7:    return $urandom;
      8:       return {s, 8'($urandom_range(60, 100)), 23'($urandom)};
      default: return {s, 8'($urandom_range(122, 132)), 23'($urandom)};
    endcase
  endfunction

  // Offer one word and wait until it is taken
  task automatic send_word(logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
                           logic [31:0] bi, logic [31:0] cr, logic [31:0] ci,
                           logic lst);
    int gap;
    in_ch.first_real  <= ar;
    in_ch.first_imag  <= ai;
    in_ch.second_real <= br;
    in_ch.second_imag <= bi;
    in_ch.sum_in_real <= cr;
    in_ch.sum_in_imag <= ci;
    in_ch.last_in     <= lst;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    gap = (quiet || hold_req) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    send_word(rand_single(), rand_single(), rand_single(), rand_single(),
              rand_single(), rand_single(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    hold_req          = 1'b0;
    quiet             = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.first_real  = '0;
    in_ch.first_imag  = '0;
    in_ch.second_real = '0;
    in_ch.second_imag = '0;
    in_ch.sum_in_real = '0;
    in_ch.sum_in_imag = '0;
    in_ch.last_in     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros and signed zero sums
    send_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_word(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 1'b1);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000,
              32'h8000_0000, 32'h8000_0000, 1'b0);
    // exact cancellation: 1.5*2 plus -3
    send_word(32'h3FC0_0000, 32'h3FC0_0000, 32'h4000_0000, 32'h0,
              32'hC040_0000, 32'hC040_0000, 1'b1);
    // infinity times zero, opposite infinities, NaN operands
    send_word(32'h7F80_0000, 32'h0, 32'h0, 32'h3F80_0000, 32'h0, 32'h0, 1'b0);
    send_word(32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000,
              32'h0, 32'h0, 1'b0);
    send_word(32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'h0, 32'hFF80_0000,
              32'h7F80_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 32'h7F80_0001, 32'h3F80_0000, 32'h3F80_0000,
              32'h0, 32'h0, 1'b0);
    send_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FC0_0001, 32'hFFC0_0000, 1'b1);
    // overflow of products and of the final sum
    send_word(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
              32'h0, 32'h0, 1'b0);
    send_word(32'h3F80_0000, 32'h0, 32'h7F7F_FFFF, 32'h0, 32'h7F7F_FFFF,
              32'hFF7F_FFFF, 1'b1);
    // subnormals, smallest and largest, and underflow of products
    send_word(32'h0000_0001, 32'h807F_FFFF, 32'h3F80_0000, 32'h3F80_0000,
              32'h0000_0001, 32'h807F_FFFF, 1'b0);
    send_word(32'h0000_0001, 32'h0080_0000, 32'h3F00_0000, 32'h0000_0001,
              32'h0, 32'h8000_0000, 1'b1);
    send_word(32'h3F00_0000, 32'h3F00_0000, 32'h0000_0003, 32'h0000_0001,
              32'h0, 32'h0, 1'b0);
    // rounding ties and far-apart exponents
    send_word(32'h3F80_0001, 32'h3F80_0001, 32'h3F80_0001, 32'h3F80_0001,
              32'h4B80_0000, 32'h3380_0000, 1'b1);
    send_word(32'h4B80_0001, 32'h0, 32'h3F80_0000, 32'h0, 32'h3F80_0000,
              32'h0000_0001, 1'b0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(32'h7F7F_FFFF, 32'h0080_0000, 32'h3380_0000, 32'h4B00_0000,
              32'hBF80_0000, 32'h3F7F_FFFF, 1'b0);

    // Random: long hold-off first, sender keeps offering back to back
    hold_req = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 40) hold_req = 1'b0;
      if (n % 200 == 100) quiet = ~quiet;
      if (n == 900) begin
        // drain everything before going on
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_random();
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (cfmac_pkg::LATENCY + 10) @(posedge clk);

    $display("Checked %0d results from %0d directed and %0d random words,", checked,
             18, RANDOM_WORDS);
    $display("covering NaN, infinity, subnormal, overflow and cancellation cases.");
    if (err_count == 0 && pending == 0) begin
      $display("** complex_float_multiply_accumulate: PASSED **");
    end else begin
      $display("** complex_float_multiply_accumulate: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
